// ----- hw/rtl/fdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdr_pkg;

    // Field widths
    localparam int FREQ_W   = 17;
    localparam int OFFS_W   = 14;
    localparam int DB_W     = 13;
    localparam int DROOP_W  = 14;
    localparam int RATED_W  = 20;
    localparam int DEM_W    = 21;
    localparam int CHG_W    = 21;
    localparam int DIS_W    = 20;
    localparam int REQ_W    = 21;
    localparam int HZ_W     = 19;
    localparam int DIFF_W   = 20;
    localparam int ABSD_W   = 18;
    localparam int MUL_W    = ABSD_W + RATED_W;
    localparam int SUM_W    = 42;

    // Pipelined restoring divider
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 10;
    localparam int PROD_W     = DIV_BITS * DIV_STAGES;
    localparam int REM_W      = DROOP_W;

    // Pipeline layout: hz, excess, multiply, divider stages, sums, output
    localparam int STG_DIV0  = 3;
    localparam int STG_SUM   = STG_DIV0 + DIV_STAGES;
    localparam int STG_OUT   = STG_SUM + 1;
    localparam int NUM_STG   = STG_OUT + 1;

    localparam int REQ_SAT   = 1000000;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOMINAL    = 3'd0,
        REG_OFFSET     = 3'd1,
        REG_OVER_DB    = 3'd2,
        REG_OVER_DROOP = 3'd3,
        REG_UNDER_DB   = 3'd4,
        REG_UNDER_DROOP= 3'd5,
        REG_MAX_RATED  = 3'd6,
        REG_MIN_RATED  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DEM_W-1:0] demand;
        logic signed [CHG_W-1:0] chg;
        logic        [DIS_W-1:0] dis;
        logic                    neg;
        logic                    pass;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] work;
    } div_t;

    // Several quotient bits of a restoring divide; quotient shifts into work.
    function automatic div_t div_step(input logic [REM_W-1:0] rem,
                                      input logic [PROD_W-1:0] work,
                                      input logic [DROOP_W-1:0] droop);
        div_t           res;
        logic [REM_W:0] trial;
        res.rem  = rem;
        res.work = work;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial    = {res.rem, res.work[PROD_W-1]};
            res.work = {res.work[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, droop}) begin
                res.rem     = REM_W'(trial - {1'b0, droop});
                res.work[0] = 1'b1;
            end
            else begin
                res.rem = trial[REM_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/frequency_droop_response.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: frequency, demand, charge and discharge limits
// m_axis    out  tvalid/tready         tdata: new demand, new limits, request; tuser: active
// cfg       in   cfg_we                cfg_index, cfg_wdata
//
// One item enters per cycle while the first stage is free to load.
// The depth is set by the divider: 4 quotient bits per stage over 10 stages.
// Reset clears every stage valid bit and loads the register defaults.
// A stage holds while it is full and the stage after it cannot load; bubbles
// close up under a stall, so input keeps flowing while a result waits at the output.

module frequency_droop_response
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // frequency_mhz, demand_kw, charge_limit_kw, discharge_limit_kw, zero pad
    input  wire logic [fdr_pkg::IN_DATA_W-1:0]  s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // new_demand_kw, new_charge_limit_kw, new_discharge_limit_kw, request_kw, zero pad
    output logic [fdr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // active
    output logic                                m_axis_tuser,

    input  wire logic                           cfg_we,
    input  wire logic [fdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration
    logic        [fdr_pkg::FREQ_W-1:0]  nominal_reg;
    logic        [fdr_pkg::OFFS_W-1:0]  offset_reg;
    logic        [fdr_pkg::DB_W-1:0]    over_db_reg;
    logic        [fdr_pkg::DROOP_W-1:0] over_droop_reg;
    logic        [fdr_pkg::DB_W-1:0]    under_db_reg;
    logic        [fdr_pkg::DROOP_W-1:0] under_droop_reg;
    logic        [fdr_pkg::RATED_W-1:0] max_rated_reg;
    logic        [fdr_pkg::RATED_W-1:0] min_rated_reg;

    // Flow control
    logic [fdr_pkg::NUM_STG-1:0] v_reg;
    logic [fdr_pkg::NUM_STG-1:0] v_next;
    logic [fdr_pkg::NUM_STG-1:0] rdy;

    // Stage 0: offset frequency
    logic signed [fdr_pkg::HZ_W-1:0]    s0_hz_reg;
    logic                               s0_over_reg;
    fdr_pkg::side_t                     s0_side_reg;

    // Stage 1: excess beyond deadband
    logic        [fdr_pkg::ABSD_W-1:0]  s1_absd_reg;
    logic        [fdr_pkg::RATED_W-1:0] s1_rated_reg;
    logic        [fdr_pkg::DROOP_W-1:0] s1_droop_reg;
    fdr_pkg::side_t                     s1_side_reg;

    // Stage 2: product
    logic        [fdr_pkg::MUL_W-1:0]   s2_prod_reg;
    logic        [fdr_pkg::DROOP_W-1:0] s2_droop_reg;
    fdr_pkg::side_t                     s2_side_reg;

    // Divider stages
    fdr_pkg::div_t                      div_reg       [fdr_pkg::DIV_STAGES];
    logic        [fdr_pkg::DROOP_W-1:0] div_droop_reg [fdr_pkg::DIV_STAGES];
    fdr_pkg::side_t                     div_side_reg  [fdr_pkg::DIV_STAGES];
    fdr_pkg::div_t                      div_next      [fdr_pkg::DIV_STAGES];

    // Sum stage
    logic signed [fdr_pkg::SUM_W-1:0]   sm_dem_reg;
    logic signed [fdr_pkg::SUM_W-1:0]   sm_chg_reg;
    logic signed [fdr_pkg::SUM_W-1:0]   sm_dis_reg;
    logic signed [fdr_pkg::SUM_W-1:0]   sm_req_reg;
    logic                               sm_basepos_reg;
    fdr_pkg::side_t                     sm_side_reg;

    // Output stage
    logic        [fdr_pkg::DEM_W-1:0]   out_dem_reg;
    logic        [fdr_pkg::CHG_W-1:0]   out_chg_reg;
    logic        [fdr_pkg::DIS_W-1:0]   out_dis_reg;
    logic        [fdr_pkg::REQ_W-1:0]   out_req_reg;
    logic                               out_act_reg;

    // Input fields
    logic        [fdr_pkg::FREQ_W-1:0]  in_freq;
    logic signed [fdr_pkg::DEM_W-1:0]   in_demand;
    logic signed [fdr_pkg::CHG_W-1:0]   in_chg;
    logic        [fdr_pkg::DIS_W-1:0]   in_dis;

    assign in_freq   = s_axis_tdata[16:0];
    assign in_demand = s_axis_tdata[37:17];
    assign in_chg    = s_axis_tdata[58:38];
    assign in_dis    = s_axis_tdata[78:59];

    //------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its content moves on
    //------------------------------------------------------------------
    always_comb
    begin
        rdy[fdr_pkg::NUM_STG-1] = !v_reg[fdr_pkg::NUM_STG-1] || m_axis_tready;
        for (int i = fdr_pkg::NUM_STG - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next = v_reg;
        if (rdy[0]) begin
            v_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < fdr_pkg::NUM_STG; i++) begin
            if (rdy[i]) begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[fdr_pkg::NUM_STG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg           <= '0;
            nominal_reg     <= fdr_pkg::FREQ_W'(60000);
            offset_reg      <= '0;
            over_db_reg     <= fdr_pkg::DB_W'(36);
            over_droop_reg  <= fdr_pkg::DROOP_W'(3000);
            under_db_reg    <= fdr_pkg::DB_W'(36);
            under_droop_reg <= fdr_pkg::DROOP_W'(3000);
            max_rated_reg   <= '0;
            min_rated_reg   <= '0;
        end
        else begin
            v_reg <= v_next;
            if (cfg_we) begin
                case (fdr_pkg::cfg_reg_t'(cfg_index))
                    fdr_pkg::REG_NOMINAL:     nominal_reg     <= cfg_wdata[fdr_pkg::FREQ_W-1:0];
                    fdr_pkg::REG_OFFSET:      offset_reg      <= cfg_wdata[fdr_pkg::OFFS_W-1:0];
                    fdr_pkg::REG_OVER_DB:     over_db_reg     <= cfg_wdata[fdr_pkg::DB_W-1:0];
                    fdr_pkg::REG_OVER_DROOP:  over_droop_reg  <= cfg_wdata[fdr_pkg::DROOP_W-1:0];
                    fdr_pkg::REG_UNDER_DB:    under_db_reg    <= cfg_wdata[fdr_pkg::DB_W-1:0];
                    fdr_pkg::REG_UNDER_DROOP: under_droop_reg <= cfg_wdata[fdr_pkg::DROOP_W-1:0];
                    fdr_pkg::REG_MAX_RATED:   max_rated_reg   <= cfg_wdata[fdr_pkg::RATED_W-1:0];
                    fdr_pkg::REG_MIN_RATED:   min_rated_reg   <= cfg_wdata[fdr_pkg::RATED_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 0: frequency plus offset, direction
    //------------------------------------------------------------------
    logic signed [fdr_pkg::HZ_W-1:0] s0_hz_next;
    logic                            s0_over_next;
    fdr_pkg::side_t                  s0_side_next;

    always_comb
    begin
        s0_hz_next   = $signed({2'b00, in_freq})
                     + $signed({{(fdr_pkg::HZ_W - fdr_pkg::OFFS_W){offset_reg[fdr_pkg::OFFS_W-1]}},
                                offset_reg});
        s0_over_next = s0_hz_next > $signed({2'b00, nominal_reg});
        s0_side_next.demand = in_demand;
        s0_side_next.chg    = in_chg;
        s0_side_next.dis    = in_dis;
        s0_side_next.neg    = 1'b0;
        s0_side_next.pass   = 1'b0;
    end

    //------------------------------------------------------------------
    // Stage 1: deadband edge, excess magnitude, droop and rated select
    //------------------------------------------------------------------
    logic signed [fdr_pkg::HZ_W-1:0]    s1_ref;
    logic signed [fdr_pkg::DIFF_W-1:0]  s1_diff;
    logic        [fdr_pkg::DROOP_W-1:0] s1_droop_next;
    logic        [fdr_pkg::RATED_W-1:0] s1_rated_next;
    fdr_pkg::side_t                     s1_side_next;

    always_comb
    begin
        if (s0_over_reg) begin
            s1_ref        = $signed({2'b00, nominal_reg}) + $signed({6'b0, over_db_reg});
            s1_diff       = $signed({s0_hz_reg[fdr_pkg::HZ_W-1], s0_hz_reg})
                          - $signed({s1_ref[fdr_pkg::HZ_W-1], s1_ref});
            s1_droop_next = over_droop_reg;
        end
        else begin
            s1_ref        = $signed({2'b00, nominal_reg}) - $signed({6'b0, under_db_reg});
            s1_diff       = $signed({s1_ref[fdr_pkg::HZ_W-1], s1_ref})
                          - $signed({s0_hz_reg[fdr_pkg::HZ_W-1], s0_hz_reg});
            s1_droop_next = under_droop_reg;
        end
        s1_rated_next = s0_side_reg.demand[fdr_pkg::DEM_W-1] ? min_rated_reg : max_rated_reg;
        s1_side_next       = s0_side_reg;
        s1_side_next.neg   = !s0_over_reg;
        // no excess past the deadband, or droop off: pass inputs through
        s1_side_next.pass  = !(s1_diff > $signed(fdr_pkg::DIFF_W'(0)))
                           || (s1_droop_next == '0);
    end

    //------------------------------------------------------------------
    // Divider stage inputs
    //------------------------------------------------------------------
    always_comb
    begin
        div_next[0] = fdr_pkg::div_step('0,
                                        {{(fdr_pkg::PROD_W - fdr_pkg::MUL_W){1'b0}}, s2_prod_reg},
                                        s2_droop_reg);
        for (int k = 1; k < fdr_pkg::DIV_STAGES; k++) begin
            div_next[k] = fdr_pkg::div_step(div_reg[k-1].rem, div_reg[k-1].work,
                                            div_droop_reg[k-1]);
        end
    end

    //------------------------------------------------------------------
    // Sum stage: signed request added to demand and both limits
    //------------------------------------------------------------------
    logic        [fdr_pkg::PROD_W-1:0] sm_mag;
    logic signed [fdr_pkg::SUM_W-1:0]  sm_req_next;
    fdr_pkg::side_t                    sm_side;

    always_comb
    begin
        sm_side     = div_side_reg[fdr_pkg::DIV_STAGES-1];
        sm_mag      = div_reg[fdr_pkg::DIV_STAGES-1].work;
        sm_req_next = $signed({{(fdr_pkg::SUM_W - fdr_pkg::PROD_W){1'b0}}, sm_mag});
        if (!sm_side.neg) begin
            sm_req_next = -sm_req_next;
        end
    end

    //------------------------------------------------------------------
    // Output stage: clamps and saturation
    //------------------------------------------------------------------
    logic signed [fdr_pkg::SUM_W-1:0] cl_max;
    logic signed [fdr_pkg::SUM_W-1:0] cl_min;
    logic signed [fdr_pkg::SUM_W-1:0] cl_lo;
    logic signed [fdr_pkg::SUM_W-1:0] cl_hi;
    logic signed [fdr_pkg::SUM_W-1:0] cl_dem;
    logic signed [fdr_pkg::SUM_W-1:0] cl_chg;
    logic signed [fdr_pkg::SUM_W-1:0] cl_dis;
    logic signed [fdr_pkg::SUM_W-1:0] cl_req;
    logic signed [fdr_pkg::SUM_W-1:0] cl_sat;

    always_comb
    begin
        cl_max = $signed({{(fdr_pkg::SUM_W - fdr_pkg::RATED_W){1'b0}}, max_rated_reg});
        cl_min = -$signed({{(fdr_pkg::SUM_W - fdr_pkg::RATED_W){1'b0}}, min_rated_reg});
        cl_sat = $signed(fdr_pkg::SUM_W'(fdr_pkg::REQ_SAT));
        if (sm_basepos_reg) begin
            cl_lo = '0;
            cl_hi = cl_max;
        end
        else begin
            cl_lo = cl_min;
            cl_hi = '0;
        end

        cl_dem = sm_dem_reg;
        if (cl_dem > cl_hi) cl_dem = cl_hi;
        else if (cl_dem < cl_lo) cl_dem = cl_lo;

        cl_chg = sm_chg_reg;
        if (cl_chg > 0) cl_chg = '0;
        else if (cl_chg < cl_min) cl_chg = cl_min;

        cl_dis = sm_dis_reg;
        if (cl_dis > cl_max) cl_dis = cl_max;
        else if (cl_dis < 0) cl_dis = '0;

        cl_req = sm_req_reg;
        if (cl_req > cl_sat) cl_req = cl_sat;
        else if (cl_req < -cl_sat) cl_req = -cl_sat;
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy[0]) begin
            s0_hz_reg   <= s0_hz_next;
            s0_over_reg <= s0_over_next;
            s0_side_reg <= s0_side_next;
        end
        if (rdy[1]) begin
            s1_absd_reg  <= s1_diff[fdr_pkg::ABSD_W-1:0];
            s1_rated_reg <= s1_rated_next;
            s1_droop_reg <= s1_droop_next;
            s1_side_reg  <= s1_side_next;
        end
        if (rdy[2]) begin
            s2_prod_reg  <= {{fdr_pkg::RATED_W{1'b0}}, s1_absd_reg}
                          * {{fdr_pkg::ABSD_W{1'b0}}, s1_rated_reg};
            s2_droop_reg <= s1_droop_reg;
            s2_side_reg  <= s1_side_reg;
        end
        if (rdy[fdr_pkg::STG_DIV0]) begin
            div_reg[0]       <= div_next[0];
            div_droop_reg[0] <= s2_droop_reg;
            div_side_reg[0]  <= s2_side_reg;
        end
        for (int k = 1; k < fdr_pkg::DIV_STAGES; k++) begin
            if (rdy[fdr_pkg::STG_DIV0 + k]) begin
                div_reg[k]       <= div_next[k];
                div_droop_reg[k] <= div_droop_reg[k-1];
                div_side_reg[k]  <= div_side_reg[k-1];
            end
        end
        if (rdy[fdr_pkg::STG_SUM]) begin
            sm_req_reg  <= sm_req_next;
            sm_dem_reg  <= $signed({{(fdr_pkg::SUM_W - fdr_pkg::DEM_W){sm_side.demand[fdr_pkg::DEM_W-1]}},
                                    sm_side.demand}) + sm_req_next;
            sm_chg_reg  <= $signed({{(fdr_pkg::SUM_W - fdr_pkg::CHG_W){sm_side.chg[fdr_pkg::CHG_W-1]}},
                                    sm_side.chg}) + sm_req_next;
            sm_dis_reg  <= $signed({{(fdr_pkg::SUM_W - fdr_pkg::DIS_W){1'b0}}, sm_side.dis})
                         + sm_req_next;
            // zero demand follows the request's direction
            sm_basepos_reg <= (!sm_side.demand[fdr_pkg::DEM_W-1] && (sm_side.demand != '0))
                           || ((sm_side.demand == '0) && sm_side.neg && (sm_mag != '0));
            sm_side_reg <= sm_side;
        end
        if (rdy[fdr_pkg::STG_OUT]) begin
            if (sm_side_reg.pass) begin
                out_dem_reg <= sm_side_reg.demand;
                out_chg_reg <= sm_side_reg.chg;
                out_dis_reg <= sm_side_reg.dis;
                out_req_reg <= '0;
                out_act_reg <= 1'b0;
            end
            else begin
                out_dem_reg <= cl_dem[fdr_pkg::DEM_W-1:0];
                out_chg_reg <= cl_chg[fdr_pkg::CHG_W-1:0];
                out_dis_reg <= cl_dis[fdr_pkg::DIS_W-1:0];
                out_req_reg <= cl_req[fdr_pkg::REQ_W-1:0];
                out_act_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tdata = {5'b0, out_req_reg, out_dis_reg, out_chg_reg, out_dem_reg};
    assign m_axis_tuser = out_act_reg;

endmodule

`default_nettype wire
